FILE: rtl/wsl_pkg.sv
// ---------------------------------------------------------------------------
// wsl_pkg
// Shared types and constants for the weekly schedule lookup block.
// ---------------------------------------------------------------------------
`default_nettype none

package wsl_pkg;

    localparam int TABLE_DEPTH = 256;

    // field widths
    localparam int OPC_W    = 2;
    localparam int IDX_W    = 8;
    localparam int MIN_W    = 16;
    localparam int LVL_W    = 8;
    localparam int CMT_W    = 9;
    localparam int WDAY_W   = 8;
    localparam int SEC_W    = 20;
    localparam int SETPT_W  = 5;

    // table sizing
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int SEL_W    = (IDX_W > CNT_W) ? IDX_W : CNT_W;
    localparam int SAT_W    = (CMT_W > CNT_W) ? CMT_W : CNT_W;

    // time conversion
    localparam int TARGET_W       = 14;   // minutes in a week fit below 2**14
    localparam int MINOFDAY_W     = 15;   // seconds / 60 for any 20-bit input
    localparam int HOUR_W         = 9;
    localparam int MINUTE_W       = 6;
    localparam int DAY_W          = 3;
    localparam int HSLOT_W        = 10;
    localparam int MINS_PER_HOUR  = 60;
    localparam int HOURS_PER_DAY  = 24;
    localparam int DAYS_PER_WEEK  = 7;
    localparam int HOURS_PER_WEEK = 168;

    // divide by 60 as multiply by reciprocal, exact over the input range
    localparam int RECIP_SEC_SHIFT = 26;
    localparam int RECIP_SEC_W     = 21;
    localparam int RECIP_SEC       = 1118482;   // ceil(2**26 / 60)
    localparam int RECIP_MIN_SHIFT = 20;
    localparam int RECIP_MIN_W     = 15;
    localparam int RECIP_MIN       = 17477;     // ceil(2**20 / 60)

    localparam logic [SETPT_W-1:0] LEVEL_OFF = 5'd31;

    typedef enum logic [OPC_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_COMMIT = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_NO_TABLE = 2'd2
    } status_t;

    // query token walking the cell row
    typedef struct packed {
        logic                active;
        logic                stop;
        logic                found;
        logic [SETPT_W-1:0]  level;
        logic [TARGET_W-1:0] target;
    } tok_t;

    typedef struct packed {
        status_t            status;
        logic [SETPT_W-1:0] temperature;
        logic               heating_on;
        logic               changed;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/wsl_cmd_if.sv
// ---------------------------------------------------------------------------
// wsl_cmd_if
// Command channel: valid/ready handshake with the input item fields.
// ---------------------------------------------------------------------------
`default_nettype none

interface wsl_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  entry_index;
    logic [15:0] entry_minutes;
    logic [7:0]  entry_level;
    logic [8:0]  entry_count;
    logic [7:0]  weekday;
    logic [19:0] seconds;

    modport source (
        output valid, opcode, entry_index, entry_minutes, entry_level,
               entry_count, weekday, seconds,
        input  ready
    );

    modport sink (
        input  valid, opcode, entry_index, entry_minutes, entry_level,
               entry_count, weekday, seconds,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/wsl_res_if.sv
// ---------------------------------------------------------------------------
// wsl_res_if
// Result channel: valid/ready handshake with the result item fields.
// ---------------------------------------------------------------------------
`default_nettype none

interface wsl_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [4:0] temperature;
    logic       heating_on;
    logic       changed;

    modport source (
        output valid, status, temperature, heating_on, changed,
        input  ready
    );

    modport sink (
        input  valid, status, temperature, heating_on, changed,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/wsl_cell.sv
// ---------------------------------------------------------------------------
// wsl_cell
// One schedule entry plus one stage of the query token path.
// ---------------------------------------------------------------------------
`default_nettype none

module wsl_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_sel,
    input  logic [wsl_pkg::MIN_W-1:0]   wr_minutes,
    input  logic [wsl_pkg::LVL_W-1:0]   wr_level,
    input  logic                        scan_en,
    input  wsl_pkg::tok_t               tok_in,
    output wsl_pkg::tok_t               tok_out
);
    import wsl_pkg::*;

    logic [MIN_W-1:0] min_reg;
    logic [LVL_W-1:0] lvl_reg;
    tok_t             tok_reg;
    tok_t             tok_next;

    // entry storage, undefined until written
    always_ff @(posedge clk)
    begin
        if (wr_sel)
        begin
            min_reg <= wr_minutes;
            lvl_reg <= wr_level;
        end
    end

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.active && !tok_in.stop && scan_en)
        begin
            if ((min_reg == '0) && (lvl_reg == '0))
            begin
                tok_next.stop = 1'b1;    // empty entry ends the table
            end
            else if (min_reg <= MIN_W'(tok_in.target))
            begin
                tok_next.found = 1'b1;
                tok_next.level = lvl_reg[SETPT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

FILE: rtl/wsl_time_conv.sv
// ---------------------------------------------------------------------------
// wsl_time_conv
// Three-stage conversion of weekday and seconds of day to minute of week.
// ---------------------------------------------------------------------------
`default_nettype none

module wsl_time_conv (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [wsl_pkg::WDAY_W-1:0]    weekday,
    input  logic [wsl_pkg::SEC_W-1:0]     seconds,
    output logic                          done,
    output logic [wsl_pkg::TARGET_W-1:0]  target,
    output logic                          out_of_range
);
    import wsl_pkg::*;

    localparam int P1_W = SEC_W + RECIP_SEC_W;
    localparam int P2_W = MINOFDAY_W + RECIP_MIN_W;

    logic [2:0]            vld_reg;

    logic [4:0]            dsum1;
    logic [3:0]            dsum2;
    logic [DAY_W-1:0]      day;
    logic [P1_W-1:0]       prod1;
    logic [P2_W-1:0]       prod2;
    logic [HOUR_W+6-1:0]   hour_x60;
    logic [MINUTE_W-1:0]   minute;
    logic [HSLOT_W-1:0]    hslot;
    logic [TARGET_W+2-1:0] tgt_full;

    logic [DAY_W-1:0]      day1_reg;
    logic [MINOFDAY_W-1:0] mod1_reg;
    logic [DAY_W-1:0]      day2_reg;
    logic [MINOFDAY_W-1:0] mod2_reg;
    logic [HOUR_W-1:0]     hour2_reg;
    logic [TARGET_W-1:0]   target_reg;
    logic                  range_reg;

    // weekday mod 7: 8 == 1 (mod 7), so fold octal digits twice
    always_comb
    begin
        dsum1 = 5'(weekday[7:6]) + 5'(weekday[5:3]) + 5'(weekday[2:0]);
        dsum2 = 4'(dsum1[4:3]) + 4'(dsum1[2:0]);
        day   = (dsum2 >= 4'(DAYS_PER_WEEK)) ? DAY_W'(dsum2 - 4'(DAYS_PER_WEEK))
                                             : DAY_W'(dsum2);
    end

    assign prod1 = P1_W'(seconds) * P1_W'(RECIP_SEC);
    assign prod2 = P2_W'(mod1_reg) * P2_W'(RECIP_MIN);

    always_comb
    begin
        hour_x60 = (HOUR_W+6)'(hour2_reg) * (HOUR_W+6)'(MINS_PER_HOUR);
        minute   = MINUTE_W'(mod2_reg - MINOFDAY_W'(hour_x60));
        hslot    = HSLOT_W'(day2_reg) * HSLOT_W'(HOURS_PER_DAY)
                   + HSLOT_W'(hour2_reg);
        tgt_full = (TARGET_W+2)'(hslot) * (TARGET_W+2)'(MINS_PER_HOUR)
                   + (TARGET_W+2)'(minute);
    end

    always_ff @(posedge clk)
    begin
        day1_reg   <= day;
        mod1_reg   <= prod1[RECIP_SEC_SHIFT +: MINOFDAY_W];
        day2_reg   <= day1_reg;
        mod2_reg   <= mod1_reg;
        hour2_reg  <= prod2[RECIP_MIN_SHIFT +: HOUR_W];
        target_reg <= tgt_full[TARGET_W-1:0];
        range_reg  <= (hslot >= HSLOT_W'(HOURS_PER_WEEK));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], start};
        end
    end

    assign done         = vld_reg[2];
    assign target       = target_reg;
    assign out_of_range = range_reg;

endmodule

`default_nettype wire

FILE: rtl/weekly_schedule_lookup_unit.sv
// ---------------------------------------------------------------------------
// weekly_schedule_lookup_unit
// Weekly set point table held in a row of cells, scanned by a query token.
// ---------------------------------------------------------------------------
// Each command beat returns one result beat, in order. Writes, commits,
// unknown opcodes and queries against an invalid table are answered
// without the conversion: the result is registered into the output register,
// or into the hold slot while the output is still waiting. A query with a
// valid table first passes the time conversion (two reciprocal multiplies
// by 1/60 and the slot math), then the token walks the entry row, registered
// in each cell, and the result goes into the output register; an out-of-week
// query returns right after the conversion, without walking the row.
// A two-deep output register lets a new command be taken while a result is
// still waiting. Entries are undefined after reset and need no clearing.
// ---------------------------------------------------------------------------
`default_nettype none

module weekly_schedule_lookup_unit (
    input  logic      clk,
    input  logic      rst_n,
    wsl_cmd_if.sink   cmd,
    wsl_res_if.source res
);
    import wsl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_SCAN = 3'b100
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               tvalid_reg;
    logic               tvalid_next;
    logic [SETPT_W-1:0] last_temp_reg;
    logic [SETPT_W-1:0] last_temp_next;
    logic               last_on_reg;
    logic               last_on_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    res_t               out_data_reg;
    res_t               out_data_next;
    logic               hold_valid_reg;
    logic               hold_valid_next;
    res_t               hold_data_reg;
    res_t               hold_data_next;

    logic               accept;
    logic               idx_ok;
    logic               wr_en;
    logic               push;
    res_t               push_data;
    logic               conv_start;
    logic               conv_done;
    logic               conv_range;
    logic [TARGET_W-1:0] conv_target;
    logic               launch;
    logic               hit_on;
    logic [SETPT_W-1:0] hit_temp;

    logic [TABLE_DEPTH-1:0] wr_sel;
    logic [TABLE_DEPTH-1:0] scan_en;
    tok_t                   tok_chain [TABLE_DEPTH+1];
    tok_t                   tail;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE) && !hold_valid_reg;
    assign idx_ok    = SEL_W'(cmd.entry_index) < SEL_W'(TABLE_DEPTH);

    wsl_time_conv u_conv (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (conv_start),
        .weekday      (cmd.weekday),
        .seconds      (cmd.seconds),
        .done         (conv_done),
        .target       (conv_target),
        .out_of_range (conv_range)
    );

    assign tok_chain[0] = '{active: launch, stop: 1'b0, found: 1'b0,
                            level: '0, target: conv_target};

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        assign wr_sel[i]  = wr_en && (SEL_W'(cmd.entry_index) == SEL_W'(i));
        assign scan_en[i] = CNT_W'(i) < count_reg;

        wsl_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .wr_sel     (wr_sel[i]),
            .wr_minutes (cmd.entry_minutes),
            .wr_level   (cmd.entry_level),
            .scan_en    (scan_en[i]),
            .tok_in     (tok_chain[i]),
            .tok_out    (tok_chain[i+1])
        );
    end

    assign tail     = tok_chain[TABLE_DEPTH];
    assign hit_on   = tail.found && (tail.level != LEVEL_OFF);
    assign hit_temp = hit_on ? tail.level : '0;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        tvalid_next    = tvalid_reg;
        last_temp_next = last_temp_reg;
        last_on_next   = last_on_reg;
        wr_en          = 1'b0;
        push           = 1'b0;
        push_data      = '0;
        conv_start     = 1'b0;
        launch         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    push = 1'b1;
                    case (op_t'(cmd.opcode))
                        OP_WRITE:
                        begin
                            wr_en = idx_ok;
                            if (idx_ok)
                            begin
                                tvalid_next = 1'b0;
                            end
                        end
                        OP_COMMIT:
                        begin
                            count_next  = (SAT_W'(cmd.entry_count) > SAT_W'(TABLE_DEPTH))
                                          ? CNT_W'(TABLE_DEPTH)
                                          : CNT_W'(cmd.entry_count);
                            tvalid_next = 1'b1;
                        end
                        OP_QUERY:
                        begin
                            if (!tvalid_reg)
                            begin
                                push_data.status = ST_NO_TABLE;
                            end
                            else
                            begin
                                push       = 1'b0;
                                conv_start = 1'b1;
                                state_next = S_CONV;
                            end
                        end
                        default:
                        begin
                            push = 1'b1;
                        end
                    endcase
                end
            end
            S_CONV:
            begin
                if (conv_done)
                begin
                    if (conv_range)
                    begin
                        push             = 1'b1;
                        push_data.status = ST_RANGE;
                        state_next       = S_IDLE;
                    end
                    else
                    begin
                        launch     = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (tail.active)
                begin
                    push                  = 1'b1;
                    push_data.status      = ST_OK;
                    push_data.temperature = hit_temp;
                    push_data.heating_on  = hit_on;
                    push_data.changed     = (hit_temp != last_temp_reg)
                                            || (hit_on != last_on_reg);
                    last_temp_next        = hit_temp;
                    last_on_next          = hit_on;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register with a hold slot behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        hold_valid_next = hold_valid_reg;
        hold_data_next  = hold_data_reg;

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (!out_valid_next && hold_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = hold_data_reg;
            hold_valid_next = 1'b0;
        end
        if (push)
        begin
            if (!out_valid_next)
            begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end
            else
            begin
                hold_valid_next = 1'b1;
                hold_data_next  = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            tvalid_reg     <= 1'b0;
            last_temp_reg  <= '0;
            last_on_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            tvalid_reg     <= tvalid_next;
            last_temp_reg  <= last_temp_next;
            last_on_reg    <= last_on_next;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        hold_data_reg <= hold_data_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.status      = out_data_reg.status;
    assign res.temperature = out_data_reg.temperature;
    assign res.heating_on  = out_data_reg.heating_on;
    assign res.changed     = out_data_reg.changed;

endmodule

`default_nettype wire
